>>> rtl/bpds_pkg.sv
// ----------------------------------------------------------------------------
// bpds_pkg
// Shared types, constants and helpers of the Blinn-Phong directional shader.
// ----------------------------------------------------------------------------
package bpds_pkg;

  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 48;
  localparam int unsigned ExpW      = 16;
  localparam int unsigned OneQ14    = 16384;

  localparam logic [CfgIdxW-1:0] REG_LIGHT_DIR  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LIGHT_COL  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_AMBIENT    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_DIFFUSE    = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_SPECULAR   = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_SPEC_EXP   = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_EYE_DIR    = 3'd6;

  localparam logic [ExpW-1:0] SpecExpReset = 16'd256;

  typedef logic signed [15:0] q14_t;
  typedef q14_t [2:0] vec3_t;

  typedef struct packed {
    logic  busy;
    vec3_t light;
    vec3_t half;
  } setup_t;

  // Magnitude of a raw component; callers keep it within +/-32768.
  function automatic logic [15:0] mag17(input logic signed [16:0] c);
    logic [16:0] m;
    m = c[16] ? 17'(-c) : 17'(c);
    return m[15:0];
  endfunction

endpackage

>>> rtl/bpds_setup.sv
// ----------------------------------------------------------------------------
// bpds_setup
// Sequencer that normalizes the light, eye and half vectors after reset or a
// register write, with a bit-serial square root and restoring divider.
// ----------------------------------------------------------------------------
module bpds_setup import bpds_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        restart_i,
  input  logic [47:0] light_dir_i,
  input  logic [47:0] eye_dir_i,
  output setup_t      setup_o
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LOAD = 5'b00010,
    ST_SQR  = 5'b00100,
    ST_ROOT = 5'b01000,
    ST_DIV  = 5'b10000
  } state_e;

  localparam logic [1:0] VecLight = 2'd0;
  localparam logic [1:0] VecEye   = 2'd1;
  localparam logic [1:0] VecHalf  = 2'd2;

  state_e state_q, state_d;
  logic [1:0] vec_q, vec_d;
  logic [1:0] idx_q, idx_d;
  logic [5:0] cnt_q, cnt_d;

  logic signed [16:0] comp_q [3], comp_d [3];
  logic [31:0] sum_q, sum_d;
  logic [63:0] rv_q, rv_d, res_q, res_d, bit_q, bit_d;
  logic [43:0] num_q, num_d, quo_q, quo_d;
  logic [29:0] rem_q, rem_d;
  vec3_t lnorm_q, lnorm_d, enorm_q, enorm_d, hnorm_q, hnorm_d;

  logic [15:0] cur_mag;
  logic [31:0] sq;
  logic [31:0] sum_nx;
  logic [29:0] len;
  logic [30:0] rem_sh;
  logic [63:0] trial;
  logic [14:0] qsat;
  q14_t        qout;

  always_comb begin
    cur_mag = mag17(comp_q[idx_q]);
    sq      = 32'(cur_mag) * 32'(cur_mag);
    sum_nx  = sum_q + sq;
    len     = res_q[29:0];
    rem_sh  = {rem_q, num_q[43]};
    trial   = res_q + bit_q;
    qsat    = (quo_q > 44'(OneQ14)) ? 15'(OneQ14) : quo_q[14:0];
    if (len == '0) begin
      qout = '0;
    end else if (comp_q[idx_q] < 0) begin
      qout = -$signed({1'b0, qsat});
    end else begin
      qout = $signed({1'b0, qsat});
    end
  end

  always_comb begin
    state_d = state_q;
    vec_d   = vec_q;
    idx_d   = idx_q;
    cnt_d   = cnt_q;
    comp_d  = comp_q;
    sum_d   = sum_q;
    rv_d    = rv_q;
    res_d   = res_q;
    bit_d   = bit_q;
    num_d   = num_q;
    quo_d   = quo_q;
    rem_d   = rem_q;
    lnorm_d = lnorm_q;
    enorm_d = enorm_q;
    hnorm_d = hnorm_q;
    unique case (state_q)
      ST_IDLE: ;
      ST_LOAD: begin
        for (int i = 0; i < 3; i++) begin
          unique case (vec_q)
            VecLight: comp_d[i] = 17'($signed(light_dir_i[16*i +: 16]));
            VecEye:   comp_d[i] = -17'($signed(eye_dir_i[16*i +: 16]));
            default:  comp_d[i] = 17'(enorm_q[i]) + 17'(lnorm_q[i]);
          endcase
        end
        sum_d   = '0;
        idx_d   = '0;
        state_d = ST_SQR;
      end
      ST_SQR: begin
        sum_d = sum_nx;
        idx_d = idx_q + 2'd1;
        if (idx_q == 2'd2) begin
          rv_d    = {4'b0, sum_nx, 28'b0};
          res_d   = '0;
          bit_d   = 64'h4000_0000_0000_0000;
          cnt_d   = '0;
          state_d = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (rv_q >= trial) begin
          rv_d  = rv_q - trial;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          cnt_d   = '0;
          idx_d   = '0;
          state_d = ST_DIV;
        end
      end
      default: begin
        if (cnt_q == 6'd0) begin
          num_d = {cur_mag, 28'b0} + {15'b0, len[29:1]};
          rem_d = '0;
          quo_d = '0;
          cnt_d = 6'd1;
        end else if (cnt_q <= 6'd44) begin
          num_d = num_q << 1;
          if (rem_sh >= {1'b0, len}) begin
            rem_d = 30'(rem_sh - {1'b0, len});
            quo_d = {quo_q[42:0], 1'b1};
          end else begin
            rem_d = rem_sh[29:0];
            quo_d = {quo_q[42:0], 1'b0};
          end
          cnt_d = cnt_q + 6'd1;
        end else begin
          unique case (vec_q)
            VecLight: lnorm_d[idx_q] = qout;
            VecEye:   enorm_d[idx_q] = qout;
            default:  hnorm_d[idx_q] = qout;
          endcase
          cnt_d = '0;
          idx_d = idx_q + 2'd1;
          if (idx_q == 2'd2) begin
            if (vec_q == VecHalf) begin
              state_d = ST_IDLE;
            end else begin
              vec_d   = vec_q + 2'd1;
              state_d = ST_LOAD;
            end
          end
        end
      end
    endcase
    // restart the whole pass on any register write
    if (restart_i) begin
      state_d = ST_LOAD;
      vec_d   = VecLight;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      vec_q   <= VecLight;
      idx_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      vec_q   <= vec_d;
      idx_q   <= idx_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    comp_q  <= comp_d;
    sum_q   <= sum_d;
    rv_q    <= rv_d;
    res_q   <= res_d;
    bit_q   <= bit_d;
    num_q   <= num_d;
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    lnorm_q <= lnorm_d;
    enorm_q <= enorm_d;
    hnorm_q <= hnorm_d;
  end

  assign setup_o.busy  = (state_q != ST_IDLE);
  assign setup_o.light = lnorm_q;
  assign setup_o.half  = hnorm_q;

endmodule

>>> rtl/blinn_phong_directional_shade_core.sv
// ----------------------------------------------------------------------------
// blinn_phong_directional_shade_core
// Per-vertex Blinn-Phong shading with one directional light, ARGB out.
// ----------------------------------------------------------------------------
// Usage:
//  - Write registers on the cfg channel (cfg_valid_i/cfg_ready_o, index and
//    data); cfg_ready_o is always high. The user must write only while no
//    item is in flight; the block itself does not enforce it.
//  - After reset and after every register write the setup sequencer
//    normalizes light, eye and half vectors; busy_o stays high for that
//    pass, which uses the bit-serial square root and the one-bit-per-cycle
//    divider.
//  - An item (a normal) is accepted at a clock edge with start_i high and
//    busy_o low. One item per cycle is taken while busy_o is low.
//  - The result is driven on color_argb_o from a register, with
//    color_valid_o high for exactly one cycle.
//  - The receiver cannot stall; results are never held or dropped.
//  - Reset clears the pipeline valid bits and loads register defaults
//    (exponent 1.0), then starts a setup pass.
// ----------------------------------------------------------------------------
module blinn_phong_directional_shade_core import bpds_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic signed [15:0]  normal_x_i,
  input  logic signed [15:0]  normal_y_i,
  input  logic signed [15:0]  normal_z_i,
  output logic                color_valid_o,
  output logic [31:0]         color_argb_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // configuration registers
  logic [47:0]     light_dir_q, light_col_q, ambient_q, diffuse_q, specular_q, eye_dir_q;
  logic [ExpW-1:0] spec_exp_q;
  logic            cfg_we;

  setup_t setup;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_dir_q <= '0;
      light_col_q <= '0;
      ambient_q   <= '0;
      diffuse_q   <= '0;
      specular_q  <= '0;
      spec_exp_q  <= SpecExpReset;
      eye_dir_q   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_LIGHT_DIR: light_dir_q <= cfg_data_i;
        REG_LIGHT_COL: light_col_q <= cfg_data_i;
        REG_AMBIENT:   ambient_q   <= cfg_data_i;
        REG_DIFFUSE:   diffuse_q   <= cfg_data_i;
        REG_SPECULAR:  specular_q  <= cfg_data_i;
        REG_SPEC_EXP:  spec_exp_q  <= cfg_data_i[ExpW-1:0];
        REG_EYE_DIR:   eye_dir_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bpds_setup u_setup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (cfg_we),
    .light_dir_i (light_dir_q),
    .eye_dir_i   (eye_dir_q),
    .setup_o     (setup)
  );

  assign busy_o = setup.busy;

  // valid bits travel alongside the data
  logic [5:0] vld_q;
  logic       accept;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[4:0], accept};
    end
  end

  // stage 1: normal times light and half, per lane
  q14_t nrm [3];
  logic signed [31:0] nl1_q [3], nh1_q [3];
  assign nrm[0] = normal_x_i;
  assign nrm[1] = normal_y_i;
  assign nrm[2] = normal_z_i;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      nl1_q[i] <= 32'(nrm[i]) * 32'(setup.light[i]);
      nh1_q[i] <= 32'(nrm[i]) * 32'(setup.half[i]);
    end
  end

  // stage 2: sum, keep the positive part, round to Q.14, clamp the half term to one
  logic signed [33:0] dl, dh;
  logic [33:0] dlr, dhr;
  logic [16:0] cos2_q;
  logic [14:0] sb2_q;

  always_comb begin
    dl  = 34'(nl1_q[0]) + 34'(nl1_q[1]) + 34'(nl1_q[2]);
    dh  = 34'(nh1_q[0]) + 34'(nh1_q[1]) + 34'(nh1_q[2]);
    dlr = (34'(dl) + 34'd8192) >> 14;
    dhr = (34'(dh) + 34'd8192) >> 14;
  end

  always_ff @(posedge clk_i) begin
    cos2_q <= (dl > 0) ? dlr[16:0] : '0;
    if (dh <= 0) begin
      sb2_q <= '0;
    end else if (dhr > 34'(OneQ14)) begin
      sb2_q <= 15'(OneQ14);
    end else begin
      sb2_q <= dhr[14:0];
    end
  end

  // stage 3: log2 of the base times exponent; light times diffuse
  logic [3:0]  lead;
  logic [31:0] shl;
  logic [19:0] nlog;
  logic [35:0] pe3_q;
  logic        e0_3_q, s0_3_q, s1_3_q;
  logic [16:0] cos3_q;
  logic [31:0] lcdc3_q [3];

  always_comb begin
    lead = '0;
    for (int i = 0; i < 14; i++) begin
      if (sb2_q[i]) lead = 4'(i);
    end
    shl  = {18'b0, sb2_q[13:0]} << (5'd16 - 5'(lead));
    nlog = {4'd14 - lead, 16'b0} - {4'b0, shl[15:0]};
  end

  always_ff @(posedge clk_i) begin
    pe3_q  <= 36'(nlog) * 36'(spec_exp_q);
    e0_3_q <= (spec_exp_q == '0);
    s0_3_q <= (sb2_q == '0);
    s1_3_q <= (sb2_q >= 15'(OneQ14));
    cos3_q <= cos2_q;
    for (int i = 0; i < 3; i++) begin
      lcdc3_q[i] <= 32'(light_col_q[16*i +: 16]) * 32'(diffuse_q[16*i +: 16]);
    end
  end

  // stage 4: exp2 back to Q1.14; diffuse term
  logic [36:0] tr;
  logic [12:0] ip;
  logic [15:0] fp;
  logic [13:0] kk;
  logic [17:0] mm;
  logic [19:0] rnd;
  logic [14:0] spow;
  logic [14:0] sp4_q;
  logic [48:0] dif4_q [3];

  always_comb begin
    tr = 37'(pe3_q) + 37'd128;
    ip = tr[36:24];
    fp = tr[23:8];
    if (fp == '0) begin
      mm = 18'd65536;
      kk = 14'(ip) + 14'd2;
    end else begin
      mm = 18'd131072 - 18'(fp);
      kk = 14'(ip) + 14'd3;
    end
    rnd = '0;
    if (kk >= 14'd20) begin
      spow = '0;
    end else begin
      rnd  = ({2'b0, mm} + (20'd1 << (kk[4:0] - 5'd1))) >> kk[4:0];
      spow = rnd[14:0];
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (e0_3_q) begin
      sp4_q <= 15'(OneQ14);
    end else if (s0_3_q) begin
      sp4_q <= '0;
    end else if (s1_3_q) begin
      sp4_q <= 15'(OneQ14);
    end else begin
      sp4_q <= spow;
    end
    for (int i = 0; i < 3; i++) begin
      dif4_q[i] <= 49'(lcdc3_q[i]) * 49'(cos3_q);
    end
  end

  // stage 5: add specular and ambient in Q.42
  logic [50:0] sum5_q [3];

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      sum5_q[i] <= 51'(dif4_q[i])
                 + (51'(31'(specular_q[16*i +: 16]) * 31'(sp4_q)) << 14)
                 + (51'(ambient_q[16*i +: 16]) << 28);
    end
  end

  // stage 6: clamp to one, scale to a byte, pack
  logic [42:0] csat [3];
  logic [50:0] scaled [3];
  logic [7:0]  bytes [3];
  logic [31:0] argb_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      csat[i]   = (sum5_q[i] > (51'd1 << 42)) ? (43'd1 << 42) : sum5_q[i][42:0];
      scaled[i] = ((51'(csat[i]) << 8) - 51'(csat[i]) + (51'd1 << 41)) >> 42;
      bytes[i]  = scaled[i][7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    argb_q <= {8'hff, bytes[2], bytes[1], bytes[0]};
  end

  assign color_valid_o = vld_q[5];
  assign color_argb_o  = argb_q;

endmodule

>>> dv/blinn_phong_directional_shade_core_test.sv
// ----------------------------------------------------------------------------
// blinn_phong_directional_shade_core_test
// Self-checking bench: drives normals and register writes, predicts each ARGB
// colour in fixed point and compares it with the strobed result.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module blinn_phong_directional_shade_core_test;
  import bpds_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;
  localparam int unsigned DrainCycles   = 12;

  logic                clk_i;
  logic                rst_ni;
  logic                start_i;
  logic                busy_o;
  logic signed [15:0]  normal_x_i;
  logic signed [15:0]  normal_y_i;
  logic signed [15:0]  normal_z_i;
  logic                color_valid_o;
  logic [31:0]         color_argb_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  blinn_phong_directional_shade_core u_top (.*);

  // Shadow copy of the register file.
  logic [47:0] sh_light_dir, sh_light_col, sh_ambient, sh_diffuse, sh_specular, sh_eye_dir;
  logic [15:0] sh_spec_exp;

  logic [31:0] colors_pending[$];
  int unsigned mismatches;
  int unsigned idle_cycles;
  int unsigned send_idle_pct;
  bit          timed_out;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint unsigned sqrt_floor(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v  -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // Scale a vector to unit length; zero stays zero.
  function automatic void unit_vec(input longint c[3], output longint o[3]);
    longint unsigned s, len, q, m;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      m = (c[i] < 0) ? -c[i] : c[i];
      s += m * m;
    end
    len = sqrt_floor(s << 28);
    for (int i = 0; i < 3; i++) begin
      m = (c[i] < 0) ? -c[i] : c[i];
      if (len == 0) begin
        o[i] = 0;
      end else begin
        q = ((m << 28) + (len >> 1)) / len;
        if (q > OneQ14) q = OneQ14;
        o[i] = (c[i] < 0) ? -longint'(q) : longint'(q);
      end
    end
  endfunction

  function automatic longint unsigned pos_dot(longint a[3], longint b[3]);
    longint d;
    d = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    if (d <= 0) return 0;
    return (longint'(d) + 8192) >>> 14;
  endfunction

  function automatic longint unsigned spec_power(longint unsigned s, longint unsigned e);
    int unsigned p;
    longint unsigned f, n, t, ip, fp, m, k;
    if (e == 0) return OneQ14;
    if (s == 0) return 0;
    if (s >= OneQ14) return OneQ14;
    p = 0;
    while ((s >> (p + 1)) != 0) p++;
    f  = (s << (16 - p)) & 64'hFFFF;
    n  = longint'(14 - p) * 65536 - f;
    t  = (n * e + 128) >> 8;
    ip = t >> 16;
    fp = t & 64'hFFFF;
    if (fp == 0) begin
      m = 65536;
      k = ip + 2;
    end else begin
      m = 131072 - fp;
      k = ip + 3;
    end
    if (k >= 20) return 0;
    return (m + (64'd1 << (k - 1))) >> k;
  endfunction

  function automatic logic [31:0] shade_color(logic signed [15:0] nx, logic signed [15:0] ny,
                                              logic signed [15:0] nz);
    longint nrm[3], lr[3], ln[3], er[3], en[3], hr[3], hn[3];
    longint unsigned cosd, sb, sp, c, byte_v;
    logic [31:0] argb;
    nrm[0] = nx; nrm[1] = ny; nrm[2] = nz;
    for (int i = 0; i < 3; i++) begin
      lr[i] = longint'($signed(sh_light_dir[16*i +: 16]));
      er[i] = -longint'($signed(sh_eye_dir[16*i +: 16]));
    end
    unit_vec(lr, ln);
    unit_vec(er, en);
    for (int i = 0; i < 3; i++) hr[i] = en[i] + ln[i];
    unit_vec(hr, hn);
    cosd = pos_dot(nrm, ln);
    sb   = pos_dot(nrm, hn);
    if (sb > OneQ14) sb = OneQ14;
    sp   = spec_power(sb, sh_spec_exp);
    argb = 32'hFF00_0000;
    for (int i = 0; i < 3; i++) begin
      c = longint'(sh_light_col[16*i +: 16]) * sh_diffuse[16*i +: 16] * cosd
        + ((longint'(sh_specular[16*i +: 16]) * sp) << 14)
        + (longint'(sh_ambient[16*i +: 16]) << 28);
      if (c > (64'd1 << 42)) c = 64'd1 << 42;
      byte_v = (c * 255 + (64'd1 << 41)) >> 42;
      argb[8*i +: 8] = byte_v[7:0];
    end
    return argb;
  endfunction

  // ------------------------------------------------------------------ checker
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni && color_valid_o) begin
      if (colors_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected color %h", color_argb_o);
      end else begin
        want = colors_pending.pop_front();
        if (want !== color_argb_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("color mismatch: expected %h actual %h", want, color_argb_o);
        end
      end
    end
  end

  // Count cycles in which nothing is accepted and no colour comes out.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || color_valid_o || (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // ------------------------------------------------------------------ drivers
  // Hold start until accepted; the expectation is taken at acceptance.
  // Start stays high after acceptance so items can follow back to back; it
  // drops in idle cycles and before register writes.
  task automatic send_normal(logic signed [15:0] nx, logic signed [15:0] ny,
                             logic signed [15:0] nz);
    while ($urandom_range(99) < send_idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i    <= 1'b1;
    normal_x_i <= nx;
    normal_y_i <= ny;
    normal_z_i <= nz;
    do @(posedge clk_i); while (busy_o);
    colors_pending.push_back(shade_color(nx, ny, nz));
  endtask

  task automatic send_rand_normal();
    logic [15:0] v[3];
    for (int i = 0; i < 3; i++) begin
      case ($urandom_range(3))
        0: v[i] = $urandom;
        default: v[i] = $urandom_range(16384) - ($urandom_range(1) ? 16384 : 0);
      endcase
    end
    send_normal(v[0], v[1], v[2]);
  endtask

  // Drain the pipeline, then write one register.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [47:0] val);
    start_i <= 1'b0;
    while (colors_pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      REG_LIGHT_DIR: sh_light_dir = val;
      REG_LIGHT_COL: sh_light_col = val;
      REG_AMBIENT:   sh_ambient   = val;
      REG_DIFFUSE:   sh_diffuse   = val;
      REG_SPECULAR:  sh_specular  = val;
      REG_SPEC_EXP:  sh_spec_exp  = val[15:0];
      REG_EYE_DIR:   sh_eye_dir   = val;
      default: ;
    endcase
  endtask

  function automatic logic [47:0] rand_vec();
    return {16'($urandom_range(32767) - 16384), 16'($urandom_range(32767) - 16384),
            16'($urandom_range(32767) - 16384)};
  endfunction

  function automatic logic [47:0] rand_col();
    return {16'($urandom_range(12000)), 16'($urandom_range(12000)),
            16'($urandom_range(12000))};
  endfunction

  task automatic load_scene(logic [47:0] ld, logic [47:0] lc, logic [47:0] am,
                            logic [47:0] df, logic [47:0] sc, logic [15:0] ex,
                            logic [47:0] ed);
    write_reg(REG_LIGHT_DIR, ld);
    write_reg(REG_LIGHT_COL, lc);
    write_reg(REG_AMBIENT, am);
    write_reg(REG_DIFFUSE, df);
    write_reg(REG_SPECULAR, sc);
    write_reg(REG_SPEC_EXP, 48'(ex));
    write_reg(REG_EYE_DIR, ed);
  endtask

  // -------------------------------------------------------------------- tests
  // Normals at field extremes and axes in a simple scene, then edge cases.
  task automatic test_directed();
    load_scene({16'sd16384, 16'sd0, 16'sd0}, {3{16'd16384}}, {3{16'd1000}},
               {3{16'd16384}}, {3{16'd16384}}, 16'd2048, {16'h8000, 16'd0, 16'd0});
    send_normal(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_normal(-16'sd32768, -16'sd32768, -16'sd32768);
    send_normal(16'sd0, 16'sd0, 16'sd0);
    send_normal(16'sd0, 16'sd0, 16'sd16384);
    send_normal(16'sd0, 16'sd0, -16'sd16384);
    send_normal(16'sd16384, 16'sd0, 16'sd0);
    send_normal(16'sd0, 16'sd16384, 16'sd0);
    send_normal(16'sd11585, 16'sd0, 16'sd11585);
    // Exponent zero gives full specular even for a zero base.
    write_reg(REG_SPEC_EXP, 48'd0);
    send_normal(16'sd0, 16'sd0, 16'sd0);
    send_normal(16'sd5000, -16'sd3000, 16'sd9000);
    // Largest exponent makes the power small unless the base is near one.
    write_reg(REG_SPEC_EXP, 48'hffff);
    send_normal(16'sd16384, 16'sd0, 16'sd0);
    send_normal(16'sd8000, 16'sd8000, 16'sd8000);
    // Zero light and eye vectors normalize to zero.
    write_reg(REG_LIGHT_DIR, 48'd0);
    write_reg(REG_EYE_DIR, 48'd0);
    send_normal(16'sd16384, 16'sd16384, 16'sd16384);
    // Saturated colour registers.
    load_scene({3{16'h8000}}, {3{16'hffff}}, {3{16'hffff}}, {3{16'hffff}},
               {3{16'hffff}}, 16'd256, {3{16'h7fff}});
    send_normal(16'sh7fff, -16'sd32768, 16'sd1);
    send_normal(-16'sd1, 16'sd1, -16'sd1);
    // Opposite light and eye make the half vector vanish.
    load_scene({16'sd0, 16'sd0, 16'sd16384}, {3{16'd9000}}, 48'd0, {3{16'd9000}},
               {3{16'd9000}}, 16'd4000, {16'sd0, 16'sd0, 16'sd16384});
    send_normal(16'sd0, 16'sd0, 16'sd16384);
    send_normal(16'sd3000, 16'sd3000, 16'sd16000);
  endtask

  // Random scenes; each phase runs a batch of random normals.
  task automatic test_random(int unsigned phases, int unsigned per_phase);
    for (int p = 0; p < phases; p++) begin
      load_scene(rand_vec(), rand_col(), {3{16'($urandom_range(3000))}}, rand_col(),
                 rand_col(), 16'($urandom_range(1) ? $urandom_range(8192) : $urandom),
                 ($urandom_range(7) == 0) ? {$urandom, 16'($urandom)} : rand_vec());
      for (int i = 0; i < per_phase; i++) send_rand_normal();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    normal_x_i    = '0;
    normal_y_i    = '0;
    normal_z_i    = '0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    mismatches    = 0;
    idle_cycles   = 0;
    send_idle_pct = 8;
    sh_light_dir = '0; sh_light_col = '0; sh_ambient = '0; sh_diffuse = '0;
    sh_specular  = '0; sh_eye_dir   = '0; sh_spec_exp = SpecExpReset;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset values: everything black except alpha.
    send_normal(16'sd16384, 16'sd0, 16'sd0);
    test_directed();
    send_idle_pct = 8;
    test_random(6, 80);
    send_idle_pct = 71;
    test_random(6, 80);
    send_idle_pct = 0;
    test_random(6, 80);

    start_i <= 1'b0;
    while (colors_pending.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
